// ===== design/lbm_pkg.sv =====
// Shared types and constants of the LED bar meter fill block.
// Used by the front, the command queue, the back and the top level.
// Depends on nothing.
package lbm_pkg;

    localparam int IDX_W     = 5;
    localparam int COLOR_W   = 24;
    localparam int VALUE_W   = 16;
    localparam int COUNT_W   = 2;
    localparam int SPAN_W    = 6;
    localparam int PROD_W    = 22;
    localparam int K_W       = 3;
    localparam int CFG_IDX_W = 3;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = 1;
    localparam int CQ_CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE0_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE0_END   = 3'd5;
    localparam int                   CFG_RANGE_STRIDE = 2;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 16'd100;
    localparam logic [COLOR_W-1:0] COLOR_BLACK     = 24'h000000;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [IDX_W-1:0]  org;
        logic              up;
        logic [SPAN_W-1:0] lit;
        logic              last;
    } t_cmd;

endpackage

// ===== design/lbm_front.sv =====
// Front part of the LED bar meter fill: accepts a reading, saturates it and
// works out the lit count of each range with a shift-subtract divider.
// Depends on lbm_pkg; feeds range commands into lbm_cmd_queue.
module lbm_front #(
    parameter int NUM_LEDS   = 32,
    parameter int MAX_RANGES = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [lbm_pkg::VALUE_W-1:0]  i_meter_value,
    input  logic [lbm_pkg::VALUE_W-1:0]  i_max_value,
    input  logic [lbm_pkg::COUNT_W-1:0]  i_range_count,
    input  logic [lbm_pkg::IDX_W-1:0]    i_range_start [MAX_RANGES],
    input  logic [lbm_pkg::IDX_W-1:0]    i_range_end [MAX_RANGES],
    output logic                         o_cmd_push,
    output lbm_pkg::t_cmd                o_cmd,
    input  logic                         i_cmd_full
);
    import lbm_pkg::*;

    localparam int RNG_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam logic [IDX_W-1:0] LED_LAST = IDX_W'(NUM_LEDS - 1);

    t_front_state      r_state, n_state;
    logic [VALUE_W-1:0] r_v, n_v;
    logic [RNG_W-1:0]  r_rng, n_rng;
    logic [RNG_W-1:0]  r_last_rng, n_last_rng;
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [SPAN_W-1:0] r_q, n_q;
    logic [SPAN_W-1:0] r_span, n_span;
    logic [K_W-1:0]    r_k, n_k;
    t_cmd              r_cmd, n_cmd;

    logic [COUNT_W-1:0] n_eff;
    logic [IDX_W-1:0]   s_clamp;
    logic [IDX_W-1:0]   e_clamp;
    logic               go_up;
    logic [SPAN_W-1:0]  span;
    logic [PROD_W-1:0]  div_sh;

    always_comb begin
        n_eff = (i_range_count > COUNT_W'(MAX_RANGES)) ? COUNT_W'(MAX_RANGES)
                                                       : i_range_count;
        s_clamp = (i_range_start[r_rng] > LED_LAST) ? LED_LAST : i_range_start[r_rng];
        e_clamp = (i_range_end[r_rng] > LED_LAST) ? LED_LAST : i_range_end[r_rng];
        go_up   = e_clamp > s_clamp;
        span    = go_up ? (SPAN_W'(e_clamp) - SPAN_W'(s_clamp) + SPAN_W'(1))
                        : (SPAN_W'(s_clamp) + SPAN_W'(1) - SPAN_W'(e_clamp));
        div_sh  = PROD_W'(i_max_value) << r_k;
    end

    always_comb begin
        n_state    = r_state;
        n_v        = r_v;
        n_rng      = r_rng;
        n_last_rng = r_last_rng;
        n_rem      = r_rem;
        n_q        = r_q;
        n_span     = r_span;
        n_k        = r_k;
        n_cmd      = r_cmd;
        o_full     = 1'b1;
        o_cmd_push = 1'b0;
        o_cmd      = r_cmd;
        o_cmd.lit  = (i_max_value == '0) ? r_span : r_q;
        case (r_state)
            FS_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_v        = (i_meter_value > i_max_value) ? i_max_value : i_meter_value;
                    n_rng      = '0;
                    n_last_rng = RNG_W'(n_eff - COUNT_W'(1));
                    if (n_eff != '0) begin
                        n_state = FS_MUL;
                    end
                end
            end
            FS_MUL: begin
                n_rem     = PROD_W'(r_v) * PROD_W'(span);
                n_q       = '0;
                n_k       = K_W'(SPAN_W - 1);
                n_span    = span;
                n_cmd.lo  = go_up ? s_clamp : e_clamp;
                n_cmd.hi  = go_up ? e_clamp : s_clamp;
                n_cmd.org = s_clamp;
                n_cmd.up  = go_up;
                n_cmd.lit = '0;
                n_cmd.last = (r_rng == r_last_rng);
                n_state   = FS_DIV;
            end
            FS_DIV: begin
                if (r_rem >= div_sh) begin
                    n_rem = r_rem - div_sh;
                    n_q   = {r_q[SPAN_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[SPAN_W-2:0], 1'b0};
                end
                if (r_k == '0) begin
                    n_state = FS_PUSH;
                end else begin
                    n_k = r_k - K_W'(1);
                end
            end
            FS_PUSH: begin
                o_cmd_push = !i_cmd_full;
                if (!i_cmd_full) begin
                    if (r_cmd.last) begin
                        n_state = FS_IDLE;
                    end else begin
                        n_rng   = RNG_W'(r_rng + 1'b1);
                        n_state = FS_MUL;
                    end
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_rng      <= n_rng;
        r_last_rng <= n_last_rng;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_span     <= n_span;
        r_k        <= n_k;
        r_cmd      <= n_cmd;
    end

    a_lit_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_PUSH && i_max_value != '0) |-> (r_q <= r_span))
        else $error("lit count exceeds range span");

    a_div_done_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_DIV && r_k == '0) |=> (r_state == FS_PUSH))
        else $error("divider did not hand over to push");

endmodule

// ===== design/lbm_cmd_queue.sv =====
// Two-entry queue of range commands between the front and the back.
// Depends on lbm_pkg for the command type and the queue sizes.
module lbm_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lbm_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import lbm_pkg::*;

    t_cmd                r_slot [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CQ_CNT_W-1:0] r_count, n_count;
    logic                do_push;
    logic                do_pop;

    always_comb begin
        o_full   = (r_count == CQ_CNT_W'(CQ_DEPTH));
        o_empty  = (r_count == '0);
        o_cmd    = r_slot[r_rd_ptr];
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = do_push ? CQ_PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_pop ? CQ_PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = CQ_CNT_W'(r_count + CQ_CNT_W'(do_push) - CQ_CNT_W'(do_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CQ_CNT_W'(CQ_DEPTH))
        else $error("command queue count out of range");

endmodule

// ===== design/lbm_back.sv =====
// Back part of the LED bar meter fill: walks each range command and emits
// one LED color write per cycle into the output register while it is free or popped.
// Depends on lbm_pkg; takes commands from lbm_cmd_queue.
module lbm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lbm_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    input  logic [lbm_pkg::COLOR_W-1:0] i_fg_color,
    input  logic [lbm_pkg::COLOR_W-1:0] i_bg_color,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [lbm_pkg::IDX_W-1:0]   o_led_index,
    output logic [lbm_pkg::COLOR_W-1:0] o_led_color,
    output logic                        o_last_write
);
    import lbm_pkg::*;

    logic               r_busy, n_busy;
    logic               r_out_valid, n_out_valid;
    t_cmd               r_cmd, n_cmd;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_last, n_last;

    logic               slot_free;
    logic [IDX_W-1:0]   led_dist;
    logic               lit_on;

    always_comb begin
        slot_free   = !r_out_valid || i_pop;
        led_dist    = r_cmd.up ? (r_i - r_cmd.org) : (r_cmd.org - r_i);
        lit_on      = {1'b0, led_dist} < r_cmd.lit;
        o_cmd_pop   = !r_busy && !i_cmd_empty;
        n_busy      = r_busy;
        n_cmd       = r_cmd;
        n_i         = r_i;
        n_out_valid = r_out_valid && !i_pop;
        n_idx       = r_idx;
        n_color     = r_color;
        n_last      = r_last;
        if (!r_busy) begin
            if (!i_cmd_empty) begin
                n_cmd  = i_cmd;
                n_i    = i_cmd.lo;
                n_busy = 1'b1;
            end
        end else if (slot_free) begin
            n_out_valid = 1'b1;
            n_idx       = r_i;
            n_color     = lit_on ? i_fg_color : i_bg_color;
            n_last      = r_cmd.last && (r_i == r_cmd.hi);
            if (r_i == r_cmd.hi) begin
                n_busy = 1'b0;
            end else begin
                n_i = r_i + IDX_W'(1);
            end
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_led_index  = r_idx;
    assign o_led_color  = r_color;
    assign o_last_write = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_i     <= n_i;
        r_idx   <= n_idx;
        r_color <= n_color;
        r_last  <= n_last;
    end

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_i >= r_cmd.lo && r_i <= r_cmd.hi))
        else $error("LED walk left its range");

endmodule

// ===== design/led_bar_meter_fill.sv =====
// Flow: the front takes a reading when full is low, then works each range in turn
// (multiply, six divide steps, push into the command queue) with full held high,
// also while the command queue is full; it takes the next reading once the last
// range command is pushed, while the back may still be writing LEDs of earlier ones.
// Reset: synchronous, active low; control and configuration registers return to their
// defaults and the command queue empties.
module led_bar_meter_fill #(
    parameter int NUM_LEDS   = 32,
    parameter int MAX_RANGES = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [lbm_pkg::VALUE_W-1:0]     i_meter_value,
    output logic                            empty,
    input  logic                            pop,
    output logic [lbm_pkg::IDX_W-1:0]       o_led_index,
    output logic [lbm_pkg::COLOR_W-1:0]     o_led_color,
    output logic                            o_last_write,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbm_pkg::COLOR_W-1:0]     i_cfg_data
);
    import lbm_pkg::*;

    logic [VALUE_W-1:0] r_max_value;
    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;
    logic [COUNT_W-1:0] r_range_count;
    logic [IDX_W-1:0]   r_range_start [MAX_RANGES];
    logic [IDX_W-1:0]   r_range_end [MAX_RANGES];

    logic cfg_we;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value   <= MAX_VALUE_RESET;
            r_fg_color    <= COLOR_BLACK;
            r_bg_color    <= COLOR_BLACK;
            r_range_count <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_VALUE:   r_max_value   <= i_cfg_data[VALUE_W-1:0];
                CFG_FG_COLOR:    r_fg_color    <= i_cfg_data;
                CFG_BG_COLOR:    r_bg_color    <= i_cfg_data;
                CFG_RANGE_COUNT: r_range_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_range
        localparam logic [CFG_IDX_W-1:0] START_IDX =
            CFG_IDX_W'(CFG_RANGE0_START + CFG_RANGE_STRIDE * g);
        localparam logic [CFG_IDX_W-1:0] END_IDX =
            CFG_IDX_W'(CFG_RANGE0_END + CFG_RANGE_STRIDE * g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_range_start[g] <= '0;
                r_range_end[g]   <= '0;
            end else if (cfg_we) begin
                if (i_cfg_index == START_IDX) begin
                    r_range_start[g] <= i_cfg_data[IDX_W-1:0];
                end
                if (i_cfg_index == END_IDX) begin
                    r_range_end[g] <= i_cfg_data[IDX_W-1:0];
                end
            end
        end
    end

    lbm_front #(
        .NUM_LEDS   (NUM_LEDS),
        .MAX_RANGES (MAX_RANGES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_meter_value (i_meter_value),
        .i_max_value   (r_max_value),
        .i_range_count (r_range_count),
        .i_range_start (r_range_start),
        .i_range_end   (r_range_end),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .i_cmd_full    (cmd_full)
    );

    lbm_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_empty (cmd_empty)
    );

    lbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_out),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_fg_color   (r_fg_color),
        .i_bg_color   (r_bg_color),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_led_index  (o_led_index),
        .o_led_color  (o_led_color),
        .o_last_write (o_last_write)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for led_bar_meter_fill: queue-style reading input, LED write
// output and a register write channel, checked against a fill predictor in this file.
// Depends on lbm_pkg and the led_bar_meter_fill top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lbm_pkg::*;

    localparam int NUM_LEDS    = 32;
    localparam int MAX_RANGES  = 2;
    localparam int DRAIN_WAIT  = 80;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 38;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE1_START =
        CFG_RANGE0_START + CFG_IDX_W'(CFG_RANGE_STRIDE);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE1_END =
        CFG_RANGE0_END + CFG_IDX_W'(CFG_RANGE_STRIDE);

    typedef struct {
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_led_write;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [VALUE_W-1:0]   i_meter_value = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [IDX_W-1:0]     o_led_index;
    logic [COLOR_W-1:0]   o_led_color;
    logic                 o_last_write;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COLOR_W-1:0]   i_cfg_data = '0;

    logic [VALUE_W-1:0]   cfg_max = MAX_VALUE_RESET;
    logic [COLOR_W-1:0]   cfg_fg = COLOR_BLACK;
    logic [COLOR_W-1:0]   cfg_bg = COLOR_BLACK;
    logic [COUNT_W-1:0]   cfg_count = '0;
    logic [IDX_W-1:0]     cfg_start [MAX_RANGES] = '{default: '0};
    logic [IDX_W-1:0]     cfg_end [MAX_RANGES] = '{default: '0};

    t_led_write fill_expect [$];
    int  fails = 0;
    int  readings_sent = 0;
    int  writes_checked = 0;
    int  configs_applied = 0;
    bit  quiet = 1'b0;
    int  pop_hold = 0;

    led_bar_meter_fill #(
        .NUM_LEDS   (NUM_LEDS),
        .MAX_RANGES (MAX_RANGES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_meter_value (i_meter_value),
        .empty         (empty),
        .pop           (pop),
        .o_led_index   (o_led_index),
        .o_led_color   (o_led_color),
        .o_last_write  (o_last_write),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic void predict_fill(input logic [VALUE_W-1:0] reading);
        t_led_write  writes [$];
        t_led_write  w;
        int unsigned n, v, s, e, span, lit, lo, hi;
        bit          up, on;
        n = (cfg_count > MAX_RANGES) ? MAX_RANGES : cfg_count;
        v = (reading > cfg_max) ? cfg_max : reading;
        for (int r = 0; r < n; r++) begin
            s = (cfg_start[r] > NUM_LEDS - 1) ? NUM_LEDS - 1 : cfg_start[r];
            e = (cfg_end[r] > NUM_LEDS - 1) ? NUM_LEDS - 1 : cfg_end[r];
            up = (e > s);
            span = up ? e - s + 1 : s + 1 - e;
            lit = (cfg_max == 0) ? span : (v * span) / cfg_max;
            lo = up ? s : e;
            hi = up ? e : s;
            for (int unsigned i = lo; i <= hi; i++) begin
                on = up ? ((i - s) < lit) : ((s - i) < lit);
                w.index = IDX_W'(i);
                w.color = on ? cfg_fg : cfg_bg;
                w.last = 1'b0;
                writes.push_back(w);
            end
        end
        if (writes.size() > 0) begin
            writes[writes.size() - 1].last = 1'b1;
        end
        foreach (writes[k]) begin
            fill_expect.push_back(writes[k]);
        end
    endfunction

    always @(negedge i_clk) begin
        if (!quiet && pop_hold == 0 && $urandom_range(0, 7) == 0) begin
            pop_hold = $urandom_range(1, 4);
        end
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_writes
        t_led_write w;
        if (i_rst_n && pop && !empty) begin
            if (fill_expect.size() == 0) begin
                $error("unexpected LED write: led_index %0d led_color %06h",
                       o_led_index, o_led_color);
                fails++;
            end else begin
                w = fill_expect.pop_front();
                writes_checked++;
                if (o_led_index !== w.index) begin
                    $error("led_index: expected %0d, actual %0d", w.index, o_led_index);
                    fails++;
                end
                if (o_led_color !== w.color) begin
                    $error("led_color: expected %06h, actual %06h", w.color, o_led_color);
                    fails++;
                end
                if (o_last_write !== w.last) begin
                    $error("last_write: expected %0b, actual %0b", w.last, o_last_write);
                    fails++;
                end
            end
        end
    end

    task automatic send_reading(input logic [VALUE_W-1:0] reading);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_meter_value <= reading;
        do @(posedge i_clk); while (full);
        predict_fill(reading);
        readings_sent++;
    endtask

    // Stops sending and waits until every expected write has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (fill_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAX_VALUE:    cfg_max = data[VALUE_W-1:0];
            CFG_FG_COLOR:     cfg_fg = data;
            CFG_BG_COLOR:     cfg_bg = data;
            CFG_RANGE_COUNT:  cfg_count = data[COUNT_W-1:0];
            CFG_RANGE0_START: cfg_start[0] = data[IDX_W-1:0];
            CFG_RANGE0_END:   cfg_end[0] = data[IDX_W-1:0];
            REG_RANGE1_START: cfg_start[1] = data[IDX_W-1:0];
            REG_RANGE1_END:   cfg_end[1] = data[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [COLOR_W-1:0] max_v, input logic [COLOR_W-1:0] fg,
                                input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] cnt,
                                input logic [COLOR_W-1:0] s0, input logic [COLOR_W-1:0] e0,
                                input logic [COLOR_W-1:0] s1, input logic [COLOR_W-1:0] e1);
        wait_drained();
        write_reg(CFG_MAX_VALUE, max_v);
        write_reg(CFG_FG_COLOR, fg);
        write_reg(CFG_BG_COLOR, bg);
        write_reg(CFG_RANGE_COUNT, cnt);
        write_reg(CFG_RANGE0_START, s0);
        write_reg(CFG_RANGE0_END, e0);
        write_reg(REG_RANGE1_START, s1);
        write_reg(REG_RANGE1_END, e1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        configs_applied++;
    endtask

    function automatic logic [COLOR_W-1:0] pick_led();
        case ($urandom_range(0, 3))
            0:       return {19'($urandom), 5'd0};
            1:       return {19'($urandom), 5'd31};
            default: return {19'($urandom), 5'($urandom_range(0, 31))};
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_reading();
        int x;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return VALUE_W'($urandom_range(0, cfg_max));
            4, 5:       return VALUE_W'($urandom);
            6: begin
                x = int'(cfg_max) + int'($urandom_range(0, 4)) - 2;
                if (x < 0) x = 0;
                if (x > 65535) x = 65535;
                return VALUE_W'(x);
            end
            default:    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Reset configuration has no ranges, so readings produce no writes.
    task automatic test_reset_state();
        send_reading(16'h0000);
        send_reading(16'hFFFF);
        wait_drained();
    endtask

    task automatic test_upward_fill();
        apply_config(24'd100, 24'hFF8000, 24'h000010, 24'd1, 24'd0, 24'd31, 24'd0, 24'd0);
        send_reading(16'd0);
        send_reading(16'd1);
        send_reading(16'd50);
        send_reading(16'd99);
        send_reading(16'd100);
        send_reading(16'd101);
        send_reading(16'hFFFF);
    endtask

    // The second range is a single LED, which counts as a downward fill.
    task automatic test_downward_fill();
        apply_config(24'd100, 24'h00FF00, 24'h0000FF, 24'd2, 24'd31, 24'd0, 24'd5, 24'd5);
        send_reading(16'd0);
        send_reading(16'd37);
        send_reading(16'd100);
        apply_config(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'd2, 24'd20, 24'd3, 24'd1, 24'd30);
        send_reading(16'hFFFE);
        send_reading(16'hFFFF);
    endtask

    task automatic test_zero_max();
        apply_config(24'd0, 24'h123456, 24'hABCDEF, 24'd2, 24'd7, 24'd2, 24'd8, 24'd12);
        send_reading(16'd0);
        send_reading(16'd12345);
    endtask

    // A range count of three is limited to the two ranges the block has.
    task automatic test_count_limit();
        apply_config(24'd80, 24'hFFFFFF, 24'h000000, 24'd3, 24'd31, 24'd31, 24'd10, 24'd20);
        send_reading(16'd0);
        send_reading(16'd40);
        send_reading(16'd80);
    endtask

    task automatic test_random_fills();
        logic [COLOR_W-1:0] max_v, cnt;
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       max_v = {8'($urandom), 16'd0};
                1:       max_v = {8'($urandom), 16'hFFFF};
                2:       max_v = {8'($urandom), 16'd1};
                3, 4:    max_v = {8'($urandom), 16'($urandom_range(1, 300))};
                default: max_v = 24'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:             cnt = {22'($urandom), 2'd0};
                1:             cnt = {22'($urandom), 2'd3};
                2, 3, 4, 5:    cnt = {22'($urandom), 2'd1};
                default:       cnt = {22'($urandom), 2'd2};
            endcase
            apply_config(max_v, 24'($urandom), 24'($urandom), cnt,
                         pick_led(), pick_led(), pick_led(), pick_led());
            if (p >= PHASES - 2) quiet = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == PHASES / 2 && k == PHASE_ITEMS / 2) wait_drained();
                send_reading(pick_reading());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_upward_fill();
        test_downward_fill();
        test_zero_max();
        test_count_limit();
        test_random_fills();
        wait_drained();
        $display("Sent %0d readings under %0d register settings; checked %0d LED writes.",
                 readings_sent, configs_applied, writes_checked);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #6ms;
        $display("Verification failed");
        $finish;
    end

endmodule
